[rtl/mbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_LEVELS_DEF = 8;

  localparam int CH_W    = 8;
  localparam int SUM_W   = 10;
  localparam int PIX_W   = 3 * CH_W;
  localparam int PSUM_W  = 3 * SUM_W;
  localparam int CFG_W   = 11;
  localparam int LVL_W   = 3;
  localparam int POS_W   = 10;
  localparam int TOT_W   = 4;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int MIN_DIM = 32;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic REG_IMG_WIDTH  = 1'b0;
  localparam logic REG_IMG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FILT
  } state_t;

  typedef struct packed {
    logic busy;
    logic restart;
  } cfg_ctrl_t;

endpackage

`default_nettype wire

[rtl/mbd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mbd_in_if;
  import mbd_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] pixel_red;
  logic [CH_W-1:0] pixel_green;
  logic [CH_W-1:0] pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);

endinterface

`default_nettype wire

[rtl/mbd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mbd_out_if;
  import mbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] mip_level;
  logic [POS_W-1:0] out_column;
  logic [POS_W-1:0] out_row;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;
  logic [TOT_W-1:0] level_total;
  logic             run_last;

  modport source (output valid, mip_level, out_column, out_row, out_red, out_green,
                  out_blue, level_total, run_last, input ready);
  modport sink   (input valid, mip_level, out_column, out_row, out_red, out_green,
                  out_blue, level_total, run_last, output ready);

endinterface

`default_nettype wire

[rtl/mbd_add3.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbd_add3 (
  input  wire logic [mbd_pkg::PSUM_W-1:0] a,
  input  wire logic [mbd_pkg::PSUM_W-1:0] b,
  output logic      [mbd_pkg::PSUM_W-1:0] sum,
  output logic      [mbd_pkg::PIX_W-1:0]  mean
);
  import mbd_pkg::*;

  logic [SUM_W-1:0] lane_sum [3];
  logic [SUM_W-1:0] lane_rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_sum[i] = a[i*SUM_W +: SUM_W] + b[i*SUM_W +: SUM_W];
      lane_rnd[i] = (lane_sum[i] + SUM_W'(2)) >> 2;
      sum[i*SUM_W +: SUM_W] = lane_sum[i];
      mean[i*CH_W +: CH_W]  = lane_rnd[i][CH_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/mbd_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbd_cfg #(
  parameter int MAX_WIDTH  = mbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mbd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_LEVELS = mbd_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mbd_pkg::APB_AW-1:0]         paddr,
  input  wire logic [mbd_pkg::APB_DW-1:0]         pwdata,
  output logic      [mbd_pkg::APB_DW-1:0]         prdata,
  output logic                                    pready,
  output logic      [$clog2(MAX_WIDTH+1)-1:0]     img_w,
  output logic      [$clog2(MAX_HEIGHT+1)-1:0]    img_h,
  output logic      [$clog2(MAX_LEVELS+1)-1:0]    lvl_count,
  output mbd_pkg::cfg_ctrl_t                      ctrl
);
  import mbd_pkg::*;

  localparam int DW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int NW = $clog2(MAX_LEVELS+1);

  logic [CFG_W-1:0] width_r, height_r;
  logic             busy_r, load_r;
  logic [NW-1:0]    cnt_r;
  logic [DW-1:0]    bw_r;
  logic [HW-1:0]    bh_r;
  logic             wr_en;
  logic             grow;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_IMG_WIDTH:  prdata = APB_DW'(width_r);
      REG_IMG_HEIGHT: prdata = APB_DW'(height_r);
      default:        prdata = '0;
    endcase
  end

  // zero acts as one, oversize saturates
  always_comb begin
    priority if (width_r == '0) begin
      img_w = DW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      img_w = DW'(MAX_WIDTH);
    end else begin
      img_w = DW'(width_r);
    end
    priority if (height_r == '0) begin
      img_h = HW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      img_h = HW'(MAX_HEIGHT);
    end else begin
      img_h = HW'(height_r);
    end
  end

  assign grow = (32'(cnt_r) < MAX_LEVELS) && !bw_r[0] && !bh_r[0] &&
                (32'(bw_r) >= MIN_DIM) && (32'(bh_r) >= MIN_DIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
      busy_r   <= 1'b1;
      load_r   <= 1'b1;
      cnt_r    <= NW'(1);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_IMG_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        REG_IMG_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        default:        width_r  <= width_r;
      endcase
      busy_r <= 1'b1;
      load_r <= 1'b1;
    end else if (load_r) begin
      load_r <= 1'b0;
      cnt_r  <= NW'(1);
    end else if (busy_r) begin
      if (grow) begin
        cnt_r <= cnt_r + NW'(1);
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_r) begin
      bw_r <= img_w;
      bh_r <= img_h;
    end else if (busy_r && grow) begin
      bw_r <= bw_r >> 1;
      bh_r <= bh_r >> 1;
    end
  end

  assign lvl_count    = cnt_r;
  assign ctrl.busy    = busy_r;
  assign ctrl.restart = wr_en;

endmodule

`default_nettype wire

[rtl/mipmap_box_downsample_chain.sv]
// The level-0 result is registered: an input moves the control to STEP, which loads it
// into the output register once that is free. Each further level the input completes
// goes through a line store read and FILT before its own STEP. Input is taken only in
// IDLE, after the last STEP of the previous one; the single shared three-lane adder and the
// one line store read port serialise levels. Reset and every register write restart the
// image and rebuild the level chain with input not ready; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module mipmap_box_downsample_chain #(
  parameter int MAX_WIDTH  = mbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mbd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_LEVELS = mbd_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  mbd_in_if.sink                          in_chan,
  mbd_out_if.source                       out_chan,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mbd_pkg::APB_AW-1:0] paddr,
  input  wire logic [mbd_pkg::APB_DW-1:0] pwdata,
  output logic      [mbd_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import mbd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int LW = $clog2(MAX_LEVELS);
  localparam int NW = $clog2(MAX_LEVELS+1);

  logic [DW-1:0] img_w;
  logic [HW-1:0] img_h;
  logic [NW-1:0] lvl_count;
  cfg_ctrl_t     ctrl;

  mbd_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .img_w     (img_w),
    .img_h     (img_h),
    .lvl_count (lvl_count),
    .ctrl      (ctrl)
  );

  state_t              state_r, state_nxt;
  logic [LW-1:0]       k_r;
  logic [PIX_W-1:0]    pix_r;
  logic [PSUM_W-1:0]   pair_r;
  logic [PSUM_W-1:0]   mem_q_r;
  logic [AW-1:0]       col_r  [MAX_LEVELS];
  logic [RW-1:0]       row_r  [MAX_LEVELS];
  logic [PSUM_W-1:0]   psum_r [MAX_LEVELS];
  logic [PSUM_W-1:0]   line_mem [MAX_WIDTH];

  logic                out_valid_r;
  logic [LVL_W-1:0]    o_level_r;
  logic [POS_W-1:0]    o_col_r, o_row_r;
  logic [PIX_W-1:0]    o_pix_r;
  logic [TOT_W-1:0]    o_total_r;
  logic                o_last_r;

  logic [AW-1:0]       cur_c;
  logic [RW-1:0]       cur_r;
  logic [PSUM_W-1:0]   pix_wide;
  logic [PSUM_W-1:0]   add_a, add_b, add_sum;
  logic [PIX_W-1:0]    add_mean;
  logic                in_fire, step_fire, has_next, go_next;
  logic                mem_we, mem_re;
  logic [DW-1:0]       lvl_w, lvl_off, c_inc;
  logic [HW-1:0]       lvl_h, r_inc;
  logic [AW-1:0]       line_idx;

  assign cur_c    = col_r[k_r];
  assign cur_r    = row_r[k_r];
  assign pix_wide = {2'b00, pix_r[2*CH_W +: CH_W], 2'b00, pix_r[CH_W +: CH_W],
                     2'b00, pix_r[0 +: CH_W]};

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign step_fire = (state_r == ST_STEP) && (!out_valid_r || out_chan.ready);
  assign has_next  = (NW'(k_r) + NW'(1)) < lvl_count;
  assign go_next   = has_next && cur_c[0] && cur_r[0];
  assign mem_we    = step_fire && has_next && cur_c[0] && !cur_r[0];
  assign mem_re    = step_fire && go_next;

  assign lvl_w    = img_w >> k_r;
  assign lvl_h    = img_h >> k_r;
  assign lvl_off  = img_w - lvl_w;
  assign line_idx = AW'(lvl_off + DW'(cur_c >> 1));
  assign c_inc    = DW'(cur_c) + DW'(1);
  assign r_inc    = HW'(cur_r) + HW'(1);

  // shared three-lane adder: horizontal pair in STEP, vertical sum in FILT
  assign add_a = (state_r == ST_FILT) ? mem_q_r : psum_r[k_r];
  assign add_b = (state_r == ST_FILT) ? pair_r  : pix_wide;

  mbd_add3 u_add3 (
    .a    (add_a),
    .b    (add_b),
    .sum  (add_sum),
    .mean (add_mean)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_STEP;
      ST_STEP: if (step_fire) state_nxt = go_next ? ST_FILT : ST_IDLE;
      ST_FILT: state_nxt = ST_STEP;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_chan.ready = (state_r == ST_IDLE) && !ctrl.busy;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r <= {in_chan.pixel_blue, in_chan.pixel_green, in_chan.pixel_red};
      k_r   <= '0;
    end else if (state_r == ST_FILT) begin
      pix_r <= add_mean;
      k_r   <= LW'(k_r + 1'b1);
    end
    if (step_fire) begin
      pair_r <= add_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[line_idx] <= add_sum;
    end
    if (mem_re) begin
      mem_q_r <= line_mem[line_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_r[i]  <= '0;
        row_r[i]  <= '0;
        psum_r[i] <= '0;
      end
    end else if (step_fire) begin
      if (has_next && !cur_c[0]) begin
        psum_r[k_r] <= pix_wide;
      end
      if (c_inc >= lvl_w) begin
        col_r[k_r] <= '0;
        row_r[k_r] <= (r_inc >= lvl_h) ? '0 : RW'(r_inc);
      end else begin
        col_r[k_r] <= AW'(c_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      o_level_r <= LVL_W'(k_r);
      o_col_r   <= POS_W'(cur_c);
      o_row_r   <= POS_W'(cur_r);
      o_pix_r   <= pix_r;
      o_total_r <= TOT_W'(lvl_count);
      o_last_r  <= !go_next;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.mip_level   = o_level_r;
  assign out_chan.out_column  = o_col_r;
  assign out_chan.out_row     = o_row_r;
  assign out_chan.out_red     = o_pix_r[0 +: CH_W];
  assign out_chan.out_green   = o_pix_r[CH_W +: CH_W];
  assign out_chan.out_blue    = o_pix_r[2*CH_W +: CH_W];
  assign out_chan.level_total = o_total_r;
  assign out_chan.run_last    = o_last_r;

  a_filt_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILT |-> $past(state_r) == ST_STEP && $past(go_next))
    else $error("filter cycle without a completed block");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_STEP && k_r == '0)
    else $error("transaction did not start at level zero");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.busy |-> !in_chan.ready)
    else $error("input taken while chain rebuilds");

  a_level_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> NW'(k_r) < lvl_count)
    else $error("level beyond chain");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire && !go_next |=> state_r == ST_IDLE)
    else $error("run did not end on last result");

endmodule

`default_nettype wire
